@@ rtl/core/wvip_pkg.sv @@
`default_nettype none

package wvip_pkg;

    // Voice dimensions and scaling
    localparam int NUM_WAVES  = 128;
    localparam int MAX_VOLUME = 255;
    localparam int PAN_CENTER = 6;

    localparam int WAVE_LEN   = 256;
    localparam int WAVE_DEPTH = NUM_WAVES * WAVE_LEN;
    localparam int ADDR_W     = $clog2(WAVE_DEPTH);

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = 8;
    localparam int WAVE_W     = 7;
    localparam int VOL_W      = 8;
    localparam int PANREG_W   = 4;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Datapath widths
    localparam int INTERP_W = 34;
    localparam int MAG_W    = 32;
    localparam int PROD_W   = MAG_W + VOL_W;
    localparam int PAN_W    = $clog2(PAN_CENTER + 1);
    localparam int SCALED_W = PROD_W + PAN_W;
    localparam int QUO_W    = SCALED_W - FRAC_W;

    // Constant divisor and its reciprocal, scaled by 2^QUO_W
    localparam int DIVISOR = MAX_VOLUME * PAN_CENTER;
    localparam int DIV_W   = $clog2(DIVISOR + 1);
    localparam longint unsigned RECIP = (64'd1 << QUO_W) / DIVISOR;

    // Register reset values
    localparam logic [PHASE_W-1:0]  PHASE_STEP_RST  = PHASE_W'(65536);
    localparam logic [WAVE_W-1:0]   WAVE_SELECT_RST = '0;
    localparam logic [VOL_W-1:0]    VOLUME_RST      = VOL_W'(255);
    localparam logic [PANREG_W-1:0] PANNING_RST     = PANREG_W'(6);

    // Input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_START  = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_WAVE_SELECT = 2'd1,
        CFG_VOLUME      = 2'd2,
        CFG_PANNING     = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

@@ rtl/core/wavetable_voice_interp_pan_top.sv @@
`default_nettype none

// Channel  | Dir | Payload (lsb first)                                   | Handshake
// s_       | in  | tuser: kind[1:0]; tdata: wave_index[6:0],             | s_tvalid/s_tready
//          |     |   entry_index[14:7], entry_value[30:15], pad[31]      |
// m_       | out | tdata: left_sample[15:0], right_sample[31:16]         | m_tvalid/m_tready
// cfg_     | in  | cfg_index, cfg_wr_data                                | cfg_wr_en
//
// Table writes, note starts and unused kinds are handled in the idle state.
// A sample word leaves idle for two reads through the single table read port, then
// interpolation, volume, pan, reciprocal and correction steps in sequence, one multiplier
// stage each, and the output load; only then is the next input word accepted.
// The result register frees the input side until a finished sample must wait on it; then no input is taken.
// Reset (synchronous, active low) clears the phase, control state and result valid flag and
// presets the voice registers; the wave table is not cleared and needs no clearing pass.

module wavetable_voice_interp_pan_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // write port for the four voice registers
    input  wire logic                              cfg_wr_en,
    input  wire logic [wvip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wvip_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // wave_index[6:0], entry_index[14:7], entry_value[30:15], zero[31]
    input  wire logic [wvip_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  wire logic [wvip_pkg::KIND_W-1:0]       s_tuser,
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // left_sample[15:0], right_sample[31:16]
    output logic [wvip_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import wvip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_MUL,
        S_MAG,
        S_PAN,
        S_RECIP,
        S_CORR,
        S_OUT
    } state_t;

    state_t state_reg;

    // Voice registers
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [WAVE_W-1:0]   wave_select_reg;
    logic [VOL_W-1:0]    volume_reg;
    logic [PANREG_W-1:0] panning_reg;
    logic [PHASE_W-1:0]  phase_reg;

    // Wave table
    logic signed [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       mem_we;

    // Datapath registers
    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [INTERP_W-1:0] interp_reg;
    logic                       sign_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [QUO_W-1:0]           n_l_reg;
    logic [QUO_W-1:0]           n_r_reg;
    logic [QUO_W-1:0]           q0_l_reg;
    logic [QUO_W-1:0]           q0_r_reg;
    logic [QUO_W-1:0]           q_l_reg;
    logic [QUO_W-1:0]           q_r_reg;
    logic                       m_tvalid_reg;
    logic [OUT_DATA_W-1:0]      m_tdata_reg;
    logic                       out_load;

    // Input word fields
    kind_t                      in_kind;
    logic [WAVE_W-1:0]          in_wave;
    logic [POS_W-1:0]           in_entry;
    logic signed [SAMPLE_W-1:0] in_value;
    logic                       in_accept;
    logic                       wr_wave_ok;
    logic                       sel_wave_ok;

    assign in_kind   = kind_t'(s_tuser);
    assign in_wave   = s_tdata[WAVE_W-1:0];
    assign in_entry  = s_tdata[WAVE_W+POS_W-1:WAVE_W];
    assign in_value  = s_tdata[WAVE_W+POS_W+SAMPLE_W-1:WAVE_W+POS_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign wr_wave_ok  = (9'(in_wave) < 9'(NUM_WAVES));
    assign sel_wave_ok = (9'(wave_select_reg) < 9'(NUM_WAVES));

    // Load the result register once it is empty or being taken
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Table write and read addresses
    assign mem_we  = in_accept && (in_kind == KIND_WRITE) && wr_wave_ok;
    assign wr_addr = ADDR_W'({in_wave, in_entry});

    always_comb begin
        unique case (state_reg)
            S_RD2:   rd_addr = ADDR_W'({wave_select_reg, phase_reg[PHASE_W-1:FRAC_W] + 8'd1});
            default: rd_addr = ADDR_W'({wave_select_reg, phase_reg[PHASE_W-1:FRAC_W]});
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wave_mem[wr_addr] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= wave_mem[rd_addr];
    end

    // Interpolate: s1*2^16 + (s2 - s1)*frac
    logic signed [SAMPLE_W:0]   diff;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [INTERP_W-1:0] interp;

    always_comb begin
        diff   = {rd_data_reg[SAMPLE_W-1], rd_data_reg} - {s1_reg[SAMPLE_W-1], s1_reg};
        frac_s = {1'b0, phase_reg[FRAC_W-1:0]};
        interp = INTERP_W'(diff * frac_s)
               + {{(INTERP_W-SAMPLE_W-FRAC_W){s1_reg[SAMPLE_W-1]}}, s1_reg, {FRAC_W{1'b0}}};
    end

    // Magnitude times volume
    logic [INTERP_W-1:0] interp_abs;
    logic [MAG_W-1:0]    mag;

    always_comb begin
        interp_abs = interp_reg[INTERP_W-1] ? INTERP_W'(-interp_reg) : INTERP_W'(interp_reg);
        mag        = interp_abs[MAG_W-1:0];
    end

    // Pan numerators from the panning register
    logic [7:0]       pan_ext;
    logic [7:0]       two_center;
    logic [PAN_W-1:0] left_num;
    logic [PAN_W-1:0] right_num;

    always_comb begin
        pan_ext    = 8'(panning_reg);
        two_center = 8'(2 * PAN_CENTER);
        left_num   = PAN_W'(PAN_CENTER);
        right_num  = PAN_W'(PAN_CENTER);
        if (pan_ext < 8'(PAN_CENTER)) begin
            right_num = PAN_W'(pan_ext);
        end else if (pan_ext > 8'(PAN_CENTER)) begin
            left_num = (pan_ext >= two_center) ? '0 : PAN_W'(two_center - pan_ext);
        end
    end

    logic [SCALED_W-1:0] scaled_l;
    logic [SCALED_W-1:0] scaled_r;

    assign scaled_l = prod_reg * left_num;
    assign scaled_r = prod_reg * right_num;

    // Reciprocal estimate, never above the true quotient and at most one below
    logic [2*QUO_W-1:0] recip_l;
    logic [2*QUO_W-1:0] recip_r;

    assign recip_l = n_l_reg * QUO_W'(RECIP);
    assign recip_r = n_r_reg * QUO_W'(RECIP);

    // Correction: bump the estimate when the remainder reaches the divisor
    logic [QUO_W+DIV_W-1:0] qd_l;
    logic [QUO_W+DIV_W-1:0] qd_r;
    logic [QUO_W-1:0]       rem_l;
    logic [QUO_W-1:0]       rem_r;

    always_comb begin
        qd_l  = q0_l_reg * DIV_W'(DIVISOR);
        qd_r  = q0_r_reg * DIV_W'(DIVISOR);
        rem_l = n_l_reg - qd_l[QUO_W-1:0];
        rem_r = n_r_reg - qd_r[QUO_W-1:0];
    end

    // Apply sign and clamp to the sample range
    function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic neg,
                                                         input logic [QUO_W-1:0] q);
        logic [SAMPLE_W-1:0] res;
        if (neg) begin
            res = (q > QUO_W'(32768)) ? 16'h8000 : SAMPLE_W'(-q);
        end else begin
            res = (q > QUO_W'(32767)) ? 16'h7FFF : q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // Voice registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg  <= PHASE_STEP_RST;
            wave_select_reg <= WAVE_SELECT_RST;
            volume_reg      <= VOLUME_RST;
            panning_reg     <= PANNING_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_wr_data[PHASE_W-1:0];
                CFG_WAVE_SELECT: wave_select_reg <= cfg_wr_data[WAVE_W-1:0];
                CFG_VOLUME:      volume_reg      <= cfg_wr_data[VOL_W-1:0];
                CFG_PANNING:     panning_reg     <= cfg_wr_data[PANREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, phase and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // fill on a finished sample, drop a taken one
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        case (in_kind)
                            KIND_START:  phase_reg <= '0;
                            KIND_SAMPLE: state_reg <= S_RD2;
                            default: ;
                        endcase
                    end
                end
                S_RD2: begin
                    s1_reg    <= rd_data_reg;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    interp_reg <= sel_wave_ok ? interp : '0;
                    phase_reg  <= phase_reg + phase_step_reg;
                    state_reg  <= S_MAG;
                end
                S_MAG: begin
                    sign_reg  <= interp_reg[INTERP_W-1];
                    prod_reg  <= mag * volume_reg;
                    state_reg <= S_PAN;
                end
                S_PAN: begin
                    n_l_reg   <= scaled_l[SCALED_W-1:FRAC_W];
                    n_r_reg   <= scaled_r[SCALED_W-1:FRAC_W];
                    state_reg <= S_RECIP;
                end
                S_RECIP: begin
                    q0_l_reg  <= recip_l[2*QUO_W-1:QUO_W];
                    q0_r_reg  <= recip_r[2*QUO_W-1:QUO_W];
                    state_reg <= S_CORR;
                end
                S_CORR: begin
                    q_l_reg   <= (rem_l >= QUO_W'(DIVISOR)) ? q0_l_reg + 1'b1 : q0_l_reg;
                    q_r_reg   <= (rem_r >= QUO_W'(DIVISOR)) ? q0_r_reg + 1'b1 : q0_r_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (out_load) begin
                        m_tdata_reg  <= {clamp_sample(sign_reg, q_r_reg),
                                         clamp_sample(sign_reg, q_l_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready)
            |=> (state_reg == S_OUT && m_tvalid_reg))
        else $error("pending sample dropped while result register busy");

    a_sample_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_kind == KIND_SAMPLE) |=> (state_reg == S_RD2))
        else $error("sample word did not start a table read");

    a_note_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_kind == KIND_START) |=> (phase_reg == '0))
        else $error("note start did not clear the phase");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_IDLE))
        else $error("table write outside idle");

    a_recip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CORR)
            |-> (rem_l < QUO_W'(2 * DIVISOR) && rem_r < QUO_W'(2 * DIVISOR)))
        else $error("reciprocal estimate off by more than one");

endmodule

`default_nettype wire

@@ sim/tb_wavetable_voice_interp_pan_top.sv @@
`default_nettype none

module tb_wavetable_voice_interp_pan_top;
    import wvip_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint FRAC_SCALE = 64'sd1 << FRAC_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 185;
    localparam int MAX_REPORTS = 10;

    // receiver pacing modes
    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_pace_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } stereo_t;

    // Voice predictor and store of expected stereo samples
    class voice_scoreboard;
        logic [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
        bit                  written [WAVE_DEPTH];
        bit [PHASE_W-1:0]    phase;
        bit [PHASE_W-1:0]    step;
        bit [WAVE_W-1:0]     wave_sel;
        bit [VOL_W-1:0]      volume;
        bit [PANREG_W-1:0]   panning;
        stereo_t             pending_samples [$];
        int                  mismatches;

        function new();
            phase      = '0;
            step       = PHASE_STEP_RST;
            wave_sel   = WAVE_SELECT_RST;
            volume     = VOLUME_RST;
            panning    = PANNING_RST;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PHASE_STEP:  step     = val[PHASE_W-1:0];
                CFG_WAVE_SELECT: wave_sel = val[WAVE_W-1:0];
                CFG_VOLUME:      volume   = val[VOL_W-1:0];
                CFG_PANNING:     panning  = val[PANREG_W-1:0];
                default: ;
            endcase
        endfunction

        // Position of a neighbor that the next sample would read unwritten, or -1
        function int hole_at();
            bit [POS_W-1:0] lo;
            bit [POS_W-1:0] hi;
            lo = phase[PHASE_W-1:FRAC_W];
            hi = lo + 1'b1;
            if (wave_sel >= NUM_WAVES) return -1;
            if (!written[{wave_sel, lo}]) return lo;
            if (!written[{wave_sel, hi}]) return hi;
            return -1;
        endfunction

        function longint entry(bit [POS_W-1:0] pos);
            if (wave_sel >= NUM_WAVES) return 0;
            return $signed(wave_mem[{wave_sel, pos}]);
        endfunction

        // Scale by volume and pan ratio, truncate toward zero, saturate
        function logic [SAMPLE_W-1:0] channel(longint blend, longint pan_num);
            longint q;
            q = blend * longint'(volume) * pan_num
                / (FRAC_SCALE * longint'(MAX_VOLUME) * longint'(PAN_CENTER));
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] word);
            logic [WAVE_W-1:0]   w;
            logic [POS_W-1:0]    e;
            bit [POS_W-1:0]      lo;
            longint              frac;
            longint              blend;
            longint              lnum;
            longint              rnum;
            longint              pv;
            stereo_t             exp_pair;
            w = word[WAVE_W-1:0];
            e = word[WAVE_W+POS_W-1:WAVE_W];
            case (kind)
                KIND_WRITE: begin
                    if (w < NUM_WAVES) begin
                        wave_mem[{w, e}] = word[WAVE_W+POS_W+SAMPLE_W-1:WAVE_W+POS_W];
                        written[{w, e}]  = 1'b1;
                    end
                end
                KIND_START: phase = '0;
                KIND_SAMPLE: begin
                    lo    = phase[PHASE_W-1:FRAC_W];
                    frac  = phase[FRAC_W-1:0];
                    blend = entry(lo) * (FRAC_SCALE - frac) + entry(lo + 1'b1) * frac;
                    lnum  = PAN_CENTER;
                    rnum  = PAN_CENTER;
                    pv    = panning;
                    if (pv < PAN_CENTER) begin
                        rnum = pv;
                    end else if (pv > PAN_CENTER) begin
                        lnum = 2 * PAN_CENTER - pv;
                        if (lnum < 0) lnum = 0;
                    end
                    exp_pair.left  = channel(blend, lnum);
                    exp_pair.right = channel(blend, rnum);
                    pending_samples.push_back(exp_pair);
                    phase = phase + step;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            stereo_t got;
            stereo_t exp_pair;
            got = word;
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample word: left %0d right %0d",
                             $signed(got.left), $signed(got.right));
                return;
            end
            exp_pair = pending_samples.pop_front();
            if (got.left !== exp_pair.left || got.right !== exp_pair.right) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("sample mismatch: left exp %0d got %0d, right exp %0d got %0d",
                             $signed(exp_pair.left), $signed(got.left),
                             $signed(exp_pair.right), $signed(got.right));
            end
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [KIND_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    voice_scoreboard sb;
    int unsigned     cycle_count = 0;
    int              burst_left  = 0;
    rx_pace_t        rx_pace     = RX_OPEN;
    int              pace_left   = 0;

    wavetable_voice_interp_pan_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_wavetable_voice_interp_pan_top NOT OK");
            $finish;
        end
    end

    // Check result words, pace m_tready on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (pace_left == 0) begin
            rx_pace   <= rx_pace_t'($urandom_range(0, 3));
            pace_left <= $urandom_range(32, 400);
        end else begin
            pace_left <= pace_left - 1;
        end
        case (rx_pace)
            RX_OPEN:   m_tready <= 1'b1;
            RX_BUSY:   m_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE: m_tready <= ($urandom_range(0, 9) < 2);
            default:   m_tready <= (cycle_count[2:0] == 3'd0);
        endcase
    end

    // Drive one word, hold until accepted, then maybe open a gap
    task automatic send_word(logic [KIND_W-1:0] kind, logic [WAVE_W-1:0] w,
                             logic [POS_W-1:0] e, logic [SAMPLE_W-1:0] v);
        logic [IN_DATA_W-1:0] word;
        int                   gap;
        word = {1'b0, v, e, w};
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, word);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Hold input, wait out all pending samples and the pipeline tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all four voice registers while idle
    task automatic configure(logic [PHASE_W-1:0] step, logic [WAVE_W-1:0] wsel,
                             logic [VOL_W-1:0] vol, logic [PANREG_W-1:0] pan);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[0] = step;
        vals[1] = CFG_DATA_W'(wsel);
        vals[2] = CFG_DATA_W'(vol);
        vals[3] = CFG_DATA_W'(pan);
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_idx_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            sb.set_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Fill one wave with random entries, extremes at both ends
    task automatic fill_wave(logic [WAVE_W-1:0] w, logic [SAMPLE_W-1:0] first,
                             logic [SAMPLE_W-1:0] last);
        logic [SAMPLE_W-1:0] v;
        for (int e = 0; e < WAVE_LEN; e++) begin
            v = SAMPLE_W'($urandom);
            if (e == 0) v = first;
            if (e == WAVE_LEN - 1) v = last;
            send_word(KIND_WRITE, w, POS_W'(e), v);
        end
    endtask

    // Mostly samples; plug a table hole first if the next sample would hit one
    task automatic random_word();
        int roll;
        int hole;
        roll = $urandom_range(0, 99);
        hole = sb.hole_at();
        if (roll < 62) begin
            if (hole < 0)
                send_word(KIND_SAMPLE, WAVE_W'($urandom), POS_W'($urandom),
                          SAMPLE_W'($urandom));
            else
                send_word(KIND_WRITE, sb.wave_sel, POS_W'(hole), SAMPLE_W'($urandom));
        end else if (roll < 80) begin
            send_word(KIND_WRITE, WAVE_W'($urandom), POS_W'($urandom), SAMPLE_W'($urandom));
        end else if (roll < 88) begin
            send_word(KIND_WRITE, sb.wave_sel, POS_W'($urandom), SAMPLE_W'($urandom));
        end else if (roll < 95) begin
            send_word(KIND_START, WAVE_W'($urandom), POS_W'($urandom), SAMPLE_W'($urandom));
        end else begin
            send_word(KIND_UNUSED, WAVE_W'($urandom), POS_W'($urandom),
                      SAMPLE_W'($urandom));
        end
    endtask

    initial begin
        logic [PHASE_W-1:0] step;
        logic [WAVE_W-1:0]  wsel;
        logic [VOL_W-1:0]   vol;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Preload two full waves with opposite extremes at the wrap point
        fill_wave(7'd0, 16'h8000, 16'h7FFF);
        fill_wave(7'd127, 16'h7FFF, 16'h8000);

        // Reset settings: unused kind, note start, unit-step samples
        send_word(KIND_UNUSED, 7'h7F, 8'hFF, 16'hFFFF);
        send_word(KIND_START, 7'd0, 8'd0, 16'd0);
        repeat (3) send_word(KIND_SAMPLE, 7'd0, 8'd0, 16'd0);

        // Neighbor wrap from 255 to 0, panning beyond full right
        configure(24'hFF8000, 7'd127, 8'd255, 4'd15);
        send_word(KIND_START, 7'd0, 8'd0, 16'd0);
        repeat (3) send_word(KIND_SAMPLE, 7'd0, 8'd0, 16'd0);

        // Largest step, silent volume, full left
        configure(24'hFFFFFF, 7'd0, 8'd0, 4'd0);
        send_word(KIND_START, 7'd0, 8'd0, 16'd0);
        repeat (2) send_word(KIND_SAMPLE, 7'd0, 8'd0, 16'd0);

        // Step of one and a half entries, full right and a pan just past it
        configure(24'h018000, 7'd0, 8'd255, 4'd12);
        send_word(KIND_START, 7'd0, 8'd0, 16'd0);
        repeat (2) send_word(KIND_SAMPLE, 7'd0, 8'd0, 16'd0);
        configure(24'h000000, 7'd127, 8'd128, 4'd13);
        repeat (2) send_word(KIND_SAMPLE, 7'd0, 8'd0, 16'd0);

        // Random phases over a spread of settings
        for (int ph = 0; ph < NUM_RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       step = '0;
                1:       step = '1;
                2:       step = PHASE_STEP_RST;
                3:       step = PHASE_W'($urandom);
                default: step = PHASE_W'($urandom_range(1, 24'h03FFFF));
            endcase
            case ($urandom_range(0, 2))
                0:       wsel = WAVE_W'($urandom);
                1:       wsel = 7'd0;
                default: wsel = 7'd127;
            endcase
            case ($urandom_range(0, 2))
                0:       vol = '0;
                1:       vol = '1;
                default: vol = VOL_W'($urandom);
            endcase
            configure(step, wsel, vol, PANREG_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 1)
                send_word(KIND_START, 7'd0, 8'd0, 16'd0);
            repeat (WORDS_PER_PHASE) random_word();
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
            $display("tb_wavetable_voice_interp_pan_top OK");
        else
            $display("tb_wavetable_voice_interp_pan_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/wvip_pkg.sv
rtl/core/wavetable_voice_interp_pan_top.sv
sim/tb_wavetable_voice_interp_pan_top.sv
